@@ design/fbt_pkg.sv @@
// shared types and constants of the failed attempt ban table
package fbt_pkg;

   localparam int SLOT_COUNT = 16;
   localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int SLOT_CNT_W = $clog2(SLOT_COUNT + 1);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_FAIL_WINDOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FAIL_LIMIT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BAN_LENGTH  = 2'd2;

   localparam logic [31:0] FAIL_WINDOW_RESET = 32'd60000;
   localparam logic [7:0]  FAIL_LIMIT_RESET  = 8'd5;
   localparam logic [31:0] BAN_LENGTH_RESET  = 32'd600000;

   localparam logic [7:0]  COUNT_MAX = 8'hFF;
   localparam logic [31:0] BAN_END_MIN = 32'd1;

   typedef enum logic [1:0] {
      KIND_CHECK = 2'd0,
      KIND_FAIL  = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_READ  = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FAIL_CALC,
      ST_FAIL_WRITE,
      ST_READ_ISSUE,
      ST_READ_EVAL
   } state_type;

   typedef struct packed {
      req_kind_type kind;
      logic [31:0]  peer_address;
      logic [31:0]  time_now;
      logic [7:0]   slot_index;
   } req_type;

   typedef struct packed {
      logic        answer_flag;
      logic [31:0] entry_address;
      logic [7:0]  entry_fail_count;
      logic [31:0] entry_window_start;
      logic [31:0] entry_ban_end;
   } rsp_type;

   typedef struct packed {
      logic [31:0] address;
      logic [7:0]  fail_count;
      logic [31:0] window_start;
      logic [31:0] ban_end;
   } slot_entry_type;

   typedef struct packed {
      logic [SLOT_IDX_W-1:0] rd_idx;
      logic                  wr_en;
      logic [SLOT_IDX_W-1:0] wr_idx;
      slot_entry_type        wr_entry;
      logic                  clr_en;
      logic [SLOT_IDX_W-1:0] clr_idx;
   } store_ctl_type;

endpackage

@@ design/fbt_slot_store.sv @@
// slot table memory with per-slot valid bits and a registered read port
module fbt_slot_store (
   input  logic                   clock,
   input  logic                   reset,
   input  fbt_pkg::store_ctl_type ctl,
   output fbt_pkg::slot_entry_type rd_entry
);

   fbt_pkg::slot_entry_type        slot_mem_ff [fbt_pkg::SLOT_COUNT];
   fbt_pkg::slot_entry_type        rd_data_ff;
   logic                           rd_valid_ff;
   logic [fbt_pkg::SLOT_COUNT-1:0] valid_ff;
   logic [fbt_pkg::SLOT_COUNT-1:0] valid_in;

   always_comb begin
      valid_in = valid_ff;
      if (ctl.wr_en) begin
         valid_in[ctl.wr_idx] = 1'b1;
      end
      if (ctl.clr_en) begin
         valid_in[ctl.clr_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         slot_mem_ff[ctl.wr_idx] <= ctl.wr_entry;
      end
      rd_data_ff <= slot_mem_ff[ctl.rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[ctl.rd_idx];
      end
   end

   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

endmodule

@@ design/failed_attempt_ban_table_top.sv @@
// failed attempt ban table: sequencer, settings and result register
//
// A request is taken when start is high and busy is low; busy then stays high
// until the result is out. Each result shows on rsp_data for exactly one cycle
// with rsp_strobe high; the receiver cannot hold it off.
// Check, record-failure and clear requests scan the sixteen slots in order
// through one registered memory read port, one slot per cycle, and may stop
// early on a hit. A failure then passes a window-test step and a count and
// ban-end update step; a slot with a ban set ends after the window test.
// The memory read port and the one slot compare behind it set the scan rate.
// Settings are written through csr_wr_en, csr_index and csr_wr_data; the user
// must write them only while the block is idle, as the block does not enforce
// this itself. An index beyond the list is ignored.
// A synchronous reset empties every slot at once through its valid bit and
// loads the default window, limit and ban length; no clearing pass is needed.
module failed_attempt_ban_table_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  fbt_pkg::req_type                   req_data,
   output logic                               rsp_strobe,
   output fbt_pkg::rsp_type                   rsp_data,
   input  logic                               csr_wr_en,
   input  logic [fbt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fbt_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   fbt_pkg::state_type      state_ff, state_in;
   fbt_pkg::req_type        req_ff, req_in;
   fbt_pkg::rsp_type        rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic [31:0]             fail_window_ff, fail_window_in;
   logic [7:0]              fail_limit_ff, fail_limit_in;
   logic [31:0]             ban_length_ff, ban_length_in;

   logic [fbt_pkg::SLOT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           eval_ff, eval_in;
   logic [fbt_pkg::SLOT_IDX_W-1:0] eval_idx_ff, eval_idx_in;

   logic                           have_empty_ff, have_empty_in;
   logic [fbt_pkg::SLOT_IDX_W-1:0] empty_at_ff, empty_at_in;
   logic                           have_old_ff, have_old_in;
   logic [fbt_pkg::SLOT_IDX_W-1:0] old_at_ff, old_at_in;
   logic [31:0]                    old_ws_ff, old_ws_in;
   logic [fbt_pkg::SLOT_IDX_W-1:0] pick_ff, pick_in;
   fbt_pkg::slot_entry_type        pick_entry_ff, pick_entry_in;

   fbt_pkg::store_ctl_type  store_ctl;
   fbt_pkg::slot_entry_type rd_entry;

   logic        addr_match;
   logic        slot_live;
   logic [31:0] live_diff;
   logic        last_eval;
   logic        check_hit;
   logic        check_expire;
   logic        clear_hit;
   logic        fail_hit;
   logic        scan_end;
   logic        issue_ok;
   logic        trk_have_empty;
   logic [fbt_pkg::SLOT_IDX_W-1:0] trk_empty_at;
   logic        trk_have_old;
   logic [fbt_pkg::SLOT_IDX_W-1:0] trk_old_at;
   logic [31:0] trk_old_ws;
   logic        restart;
   logic [7:0]  base_count;
   logic [7:0]  next_count;
   logic [31:0] ban_sum;
   logic        ban_now;
   logic        read_in_range;

   fbt_slot_store u_store (
      .clock    (clock),
      .reset    (reset),
      .ctl      (store_ctl),
      .rd_entry (rd_entry)
   );

   // scan decode
   always_comb begin
      addr_match   = (rd_entry.address == req_ff.peer_address);
      live_diff    = req_ff.time_now - rd_entry.ban_end;
      slot_live    = live_diff[31];
      last_eval    = eval_ff &&
                     (eval_idx_ff == fbt_pkg::SLOT_IDX_W'(fbt_pkg::SLOT_COUNT - 1));
      check_hit    = eval_ff && (req_ff.kind == fbt_pkg::KIND_CHECK) && addr_match &&
                     (rd_entry.ban_end != '0) && slot_live;
      check_expire = eval_ff && (req_ff.kind == fbt_pkg::KIND_CHECK) && addr_match &&
                     (rd_entry.ban_end != '0) && !slot_live;
      clear_hit    = eval_ff && (req_ff.kind == fbt_pkg::KIND_CLEAR) && addr_match;
      fail_hit     = eval_ff && (req_ff.kind == fbt_pkg::KIND_FAIL) && addr_match;
      scan_end     = check_hit || clear_hit || fail_hit || last_eval;
      issue_ok     = (cnt_ff < fbt_pkg::SLOT_CNT_W'(fbt_pkg::SLOT_COUNT));

      trk_have_empty = have_empty_ff;
      trk_empty_at   = empty_at_ff;
      trk_have_old   = have_old_ff;
      trk_old_at     = old_at_ff;
      trk_old_ws     = old_ws_ff;
      if (eval_ff && !addr_match) begin
         if (rd_entry.address == '0) begin
            if (!have_empty_ff) begin
               trk_have_empty = 1'b1;
               trk_empty_at   = eval_idx_ff;
            end
         end else if ((rd_entry.ban_end == '0) &&
                      (!have_old_ff || (rd_entry.window_start < old_ws_ff))) begin
            trk_have_old = 1'b1;
            trk_old_at   = eval_idx_ff;
            trk_old_ws   = rd_entry.window_start;
         end
      end

      restart    = (pick_entry_ff.fail_count == '0) ||
                   ((req_ff.time_now - pick_entry_ff.window_start) > fail_window_ff);
      base_count = restart ? 8'd0 : pick_entry_ff.fail_count;
      next_count = (base_count == fbt_pkg::COUNT_MAX) ? fbt_pkg::COUNT_MAX
                                                       : base_count + 8'd1;
      ban_sum    = req_ff.time_now + ban_length_ff;
      ban_now    = (pick_entry_ff.fail_count >= fail_limit_ff);
      read_in_range = ({1'b0, req_ff.slot_index} < 9'(fbt_pkg::SLOT_COUNT));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fbt_pkg::ST_IDLE: begin
            if (start) begin
               state_in = (req_data.kind == fbt_pkg::KIND_READ) ? fbt_pkg::ST_READ_ISSUE
                                                                : fbt_pkg::ST_SCAN;
            end
         end
         fbt_pkg::ST_SCAN: begin
            if (scan_end) begin
               state_in = (req_ff.kind == fbt_pkg::KIND_FAIL) ? fbt_pkg::ST_FAIL_CALC
                                                              : fbt_pkg::ST_IDLE;
            end
         end
         fbt_pkg::ST_FAIL_CALC: begin
            state_in = (pick_entry_ff.ban_end != '0) ? fbt_pkg::ST_IDLE
                                                     : fbt_pkg::ST_FAIL_WRITE;
         end
         fbt_pkg::ST_FAIL_WRITE: state_in = fbt_pkg::ST_IDLE;
         fbt_pkg::ST_READ_ISSUE: state_in = fbt_pkg::ST_READ_EVAL;
         fbt_pkg::ST_READ_EVAL:  state_in = fbt_pkg::ST_IDLE;
         default:                state_in = fbt_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = 1'b0;
      cnt_in        = cnt_ff;
      eval_in       = 1'b0;
      eval_idx_in   = eval_idx_ff;
      have_empty_in = have_empty_ff;
      empty_at_in   = empty_at_ff;
      have_old_in   = have_old_ff;
      old_at_in     = old_at_ff;
      old_ws_in     = old_ws_ff;
      pick_in       = pick_ff;
      pick_entry_in = pick_entry_ff;

      store_ctl          = '0;
      store_ctl.rd_idx   = cnt_ff[fbt_pkg::SLOT_IDX_W-1:0];
      store_ctl.wr_idx   = pick_ff;
      store_ctl.wr_entry = pick_entry_ff;
      store_ctl.clr_idx  = eval_idx_ff;

      fail_window_in = fail_window_ff;
      fail_limit_in  = fail_limit_ff;
      ban_length_in  = ban_length_ff;
      if (csr_wr_en) begin
         case (csr_index)
            fbt_pkg::CSR_FAIL_WINDOW: fail_window_in = csr_wr_data;
            fbt_pkg::CSR_FAIL_LIMIT:  fail_limit_in  = csr_wr_data[7:0];
            fbt_pkg::CSR_BAN_LENGTH:  ban_length_in  = csr_wr_data;
            default: ;
         endcase
      end

      case (state_ff)
         fbt_pkg::ST_IDLE: begin
            if (start) begin
               req_in        = req_data;
               cnt_in        = '0;
               have_empty_in = 1'b0;
               have_old_in   = 1'b0;
            end
         end
         fbt_pkg::ST_SCAN: begin
            if (!scan_end && issue_ok) begin
               eval_in     = 1'b1;
               eval_idx_in = cnt_ff[fbt_pkg::SLOT_IDX_W-1:0];
               cnt_in      = cnt_ff + fbt_pkg::SLOT_CNT_W'(1);
            end
            have_empty_in = trk_have_empty;
            empty_at_in   = trk_empty_at;
            have_old_in   = trk_have_old;
            old_at_in     = trk_old_at;
            old_ws_in     = trk_old_ws;
            if (check_expire || clear_hit) begin
               store_ctl.clr_en = 1'b1;
            end
            if (fail_hit) begin
               pick_in       = eval_idx_ff;
               pick_entry_in = rd_entry;
            end else if (last_eval && (req_ff.kind == fbt_pkg::KIND_FAIL)) begin
               pick_in = trk_have_empty ? trk_empty_at :
                         (trk_have_old ? trk_old_at : '0);
               pick_entry_in         = '0;
               pick_entry_in.address = req_ff.peer_address;
            end
            if (scan_end && (req_ff.kind != fbt_pkg::KIND_FAIL)) begin
               rsp_valid_in       = 1'b1;
               rsp_in             = '0;
               rsp_in.answer_flag = check_hit || clear_hit;
            end
         end
         fbt_pkg::ST_FAIL_CALC: begin
            if (pick_entry_ff.ban_end != '0) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
            end else begin
               pick_entry_in.fail_count   = next_count;
               pick_entry_in.window_start = restart ? req_ff.time_now
                                                    : pick_entry_ff.window_start;
            end
         end
         fbt_pkg::ST_FAIL_WRITE: begin
            store_ctl.wr_en = 1'b1;
            if (ban_now) begin
               store_ctl.wr_entry.ban_end = (ban_sum == '0) ? fbt_pkg::BAN_END_MIN
                                                            : ban_sum;
            end
            rsp_valid_in       = 1'b1;
            rsp_in             = '0;
            rsp_in.answer_flag = ban_now;
         end
         fbt_pkg::ST_READ_ISSUE: begin
            store_ctl.rd_idx = req_ff.slot_index[fbt_pkg::SLOT_IDX_W-1:0];
         end
         fbt_pkg::ST_READ_EVAL: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
            if (read_in_range && (rd_entry.address != '0) &&
                (rd_entry.ban_end != '0) && slot_live) begin
               rsp_in.answer_flag        = 1'b1;
               rsp_in.entry_address      = rd_entry.address;
               rsp_in.entry_fail_count   = rd_entry.fail_count;
               rsp_in.entry_window_start = rd_entry.window_start;
               rsp_in.entry_ban_end      = rd_entry.ban_end;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= fbt_pkg::ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         eval_ff        <= 1'b0;
         fail_window_ff <= fbt_pkg::FAIL_WINDOW_RESET;
         fail_limit_ff  <= fbt_pkg::FAIL_LIMIT_RESET;
         ban_length_ff  <= fbt_pkg::BAN_LENGTH_RESET;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         eval_ff        <= eval_in;
         fail_window_ff <= fail_window_in;
         fail_limit_ff  <= fail_limit_in;
         ban_length_ff  <= ban_length_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      rsp_ff        <= rsp_in;
      cnt_ff        <= cnt_in;
      eval_idx_ff   <= eval_idx_in;
      have_empty_ff <= have_empty_in;
      empty_at_ff   <= empty_at_in;
      have_old_ff   <= have_old_in;
      old_at_ff     <= old_at_in;
      old_ws_ff     <= old_ws_in;
      pick_ff       <= pick_in;
      pick_entry_ff <= pick_entry_in;
   end

   assign busy       = (state_ff != fbt_pkg::ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule
